### design/sts_pkg.sv
// Shared types, constants and the sine table function of the sine tone sample generator.
// Used by all design files but sts_ram, through scoped names; depends on nothing.
package sts_pkg;

  // Default structural parameters
  localparam int DEFAULT_MAX_CHANNELS   = 8;
  localparam int DEFAULT_PHASE_BITS     = 32;
  localparam int DEFAULT_SINE_ADDR_BITS = 10;

  // Fixed widths
  localparam int SINE_WIDTH   = 16;
  localparam int AMP_WIDTH    = 15;
  localparam int WORD_WIDTH   = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;

  // Register reset values
  localparam logic [31:0]          RESET_PHASE_INC   = 32'd89210049;
  localparam logic [AMP_WIDTH-1:0] RESET_AMPLITUDE   = 15'd1966;
  localparam logic [3:0]           RESET_CHANNEL_CNT = 4'd2;

  // Format conversion constants
  localparam int          PCM16_SHIFT     = 15;
  localparam int          PCM24_SHIFT     = 23;
  localparam int          PCM32_SHIFT     = 31;
  localparam logic [63:0] PCM_ROUND       = 64'h0000_0000_8000_0000;
  localparam logic [31:0] PCM16_MASK      = 32'h0000_FFFF;
  localparam logic [31:0] PCM24_MASK      = 32'h00FF_FFFF;
  localparam logic [7:0]  FLOAT_EXP_BASE  = 8'd95;   // 127 - 32
  localparam logic [4:0]  NORM_TOP_POS    = 5'd30;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_INC   = 2'd0,
    CFG_AMPLITUDE   = 2'd1,
    CFG_FORMAT      = 2'd2,
    CFG_CHANNEL_CNT = 2'd3
  } cfg_index_t;

  // Sample formats
  typedef enum logic [1:0] {
    FMT_FLOAT32 = 2'd0,
    FMT_PCM16   = 2'd1,
    FMT_PCM24   = 2'd2,
    FMT_PCM32   = 2'd3
  } fmt_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_NORM,
    BK_PACK,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic restart;
    logic block_last;
  } frame_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] sample_word;
    logic [2:0]            channel_index;
    logic                  last_channel;
    logic                  frame_block_last;
  } sample_t;

  typedef struct packed {
    logic [SINE_WIDTH-1:0] sine;
    logic                  neg;
    logic                  block_last;
  } qentry_t;

  typedef struct packed {
    logic [31:0]          phase_increment;
    logic [AMP_WIDTH-1:0] amplitude;
    fmt_t                 out_format;
    logic [3:0]           channel_count;
  } cfg_t;

  // Quarter-wave entry k: sin((pi/2)*(k+0.5)/2^addr_bits) in Q0.16,
  // by a seven-term Taylor series in Q30. Evaluated at elaboration only.
  function automatic logic [SINE_WIDTH-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned addr_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (addr_bits + 1);
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) + 64'd8192) >> 14;
    return (v > 64'd65535) ? 16'hFFFF : v[SINE_WIDTH-1:0];
  endfunction

endpackage

### design/sine_tone_sample_generator.sv
// Usage
//   Frame channel: frame_valid / frame_stall / frame_data (restart, block_last). One
//   transaction is one audio frame tick. restart zeroes the phase before the frame.
//   Sample channel: sample_valid / sample_stall / sample_data. Each frame yields one
//   transaction per configured channel (1..MAX_CHANNELS), same sample word, rising
//   channel_index, last_channel set on the final one, frame_block_last copied.
//   Config: cfg_we writes cfg_data into the register cfg_index at the clock edge;
//   write only while idle.
// Flow
//   The front end accepts a frame, reads the table RAM and pushes the entry into
//   the queue once it has room; it takes no new frame before that push. The back
//   end then runs IDLE, MUL, SCALE, PACK and EMIT for PCM formats; float32 has NORM
//   in place of SCALE, where the leading-one search shifts by 8 or 1 per cycle.
//   The back end's loop over the channels of each frame sets the sustained rate.
//   A two-entry queue lets the front end run ahead of the back end.
// Reset
//   rst clears phase and registers to their defaults, then all 2^SINE_ADDR_BITS
//   entries of the sine table RAM (1024 by default) are loaded with frame_stall high.
//   While sample_stall is high the current sample holds; frames queue up to two deep.
// Top level; depends on sts_pkg, sts_front, sts_queue, sts_back.
module sine_tone_sample_generator #(
  parameter int MAX_CHANNELS   = sts_pkg::DEFAULT_MAX_CHANNELS,
  parameter int PHASE_BITS     = sts_pkg::DEFAULT_PHASE_BITS,
  parameter int SINE_ADDR_BITS = sts_pkg::DEFAULT_SINE_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  sts_pkg::frame_t                  frame_data,
  output logic                             sample_valid,
  input  logic                             sample_stall,
  output sts_pkg::sample_t                 sample_data,
  input  logic                             cfg_we,
  input  logic [sts_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  sts_pkg::cfg_t    cfg;
  sts_pkg::qentry_t push_data;
  sts_pkg::qentry_t pop_data;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment <= sts_pkg::RESET_PHASE_INC;
      cfg.amplitude       <= sts_pkg::RESET_AMPLITUDE;
      cfg.out_format      <= sts_pkg::FMT_FLOAT32;
      cfg.channel_count   <= sts_pkg::RESET_CHANNEL_CNT;
    end else if (cfg_we) begin
      unique case (sts_pkg::cfg_index_t'(cfg_index))
        sts_pkg::CFG_PHASE_INC:   cfg.phase_increment <= cfg_data;
        sts_pkg::CFG_AMPLITUDE:   cfg.amplitude <= cfg_data[sts_pkg::AMP_WIDTH-1:0];
        sts_pkg::CFG_FORMAT:      cfg.out_format <= sts_pkg::fmt_t'(cfg_data[1:0]);
        sts_pkg::CFG_CHANNEL_CNT: cfg.channel_count <= cfg_data[3:0];
      endcase
    end
  end

  sts_front #(
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .phase_increment(cfg.phase_increment),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_data     (frame_data),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  sts_queue #(
    .DEPTH(sts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  sts_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_data      (pop_data),
    .q_empty     (empty),
    .q_pop       (pop),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_data (sample_data)
  );

endmodule

### design/sts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; width and depth come from parameters.
module sts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read that holds without a read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sts_front.sv
// Front end: table fill after reset, phase accumulator, quadrant folding and table lookup.
// Depends on sts_pkg and sts_ram; pushes one entry per frame into the queue.
module sts_front #(
  parameter int PHASE_BITS     = sts_pkg::DEFAULT_PHASE_BITS,
  parameter int SINE_ADDR_BITS = sts_pkg::DEFAULT_SINE_ADDR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      phase_increment,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  sts_pkg::frame_t  frame_data,
  output logic             push,
  output sts_pkg::qentry_t push_data,
  input  logic             full
);

  localparam int ROM_SIZE = 1 << SINE_ADDR_BITS;
  localparam int SW       = sts_pkg::SINE_WIDTH;

  logic                      fill_active;
  logic [SINE_ADDR_BITS-1:0] fill_addr;
  logic [PHASE_BITS-1:0]     acc;
  logic [PHASE_BITS-1:0]     ph;
  logic [PHASE_BITS-1:0]     inc_ext;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [SINE_ADDR_BITS-1:0] rd_addr;
  logic                      accept;
  logic                      pend_valid;
  logic                      pend_neg;
  logic                      pend_blast;
  logic [SW-1:0]             rom_rdata;
  logic [SW-1:0]             sine_rom [ROM_SIZE];

  // Constant quarter-wave table, copied into the RAM after reset
  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
    assign sine_rom[k] = sts_pkg::sine_entry(k, SINE_ADDR_BITS);
  end

  // Accept a frame only when the table is loaded and no lookup is pending
  assign frame_stall = fill_active || pend_valid;
  assign accept      = frame_valid && !frame_stall;

  // Phase of this frame and the folded table address
  assign ph      = frame_data.restart ? '0 : acc;
  assign inc_ext = PHASE_BITS'({{PHASE_BITS{1'b0}}, phase_increment});
  assign quad    = ph[PHASE_BITS-1 -: 2];
  assign idx     = ph[PHASE_BITS-3 -: SINE_ADDR_BITS];
  assign rd_addr = quad[0] ? ~idx : idx;

  // Fill sweep, phase advance and lookup tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_active <= 1'b1;
      fill_addr   <= '0;
      acc         <= '0;
      pend_valid  <= 1'b0;
    end else begin
      if (fill_active) begin
        fill_addr <= fill_addr + 1'b1;
        if (&fill_addr) begin
          fill_active <= 1'b0;
        end
      end
      if (accept) begin
        acc        <= ph + inc_ext;
        pend_valid <= 1'b1;
      end else if (pend_valid && !full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Hold frame attributes alongside the table read
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_neg   <= quad[1];
      pend_blast <= frame_data.block_last;
    end
  end

  sts_ram #(
    .WIDTH(SW),
    .DEPTH(ROM_SIZE)
  ) u_sine_ram (
    .clk  (clk),
    .we   (fill_active),
    .waddr(fill_addr),
    .wdata(sine_rom[fill_addr]),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rom_rdata)
  );

  // Push the looked-up entry once the queue has room
  assign push                 = pend_valid && !full;
  assign push_data.sine       = rom_rdata;
  assign push_data.neg        = pend_neg;
  assign push_data.block_last = pend_blast;

`ifndef NO_ASSERTIONS
  a_no_lookup_during_fill: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !fill_active)
    else $error("table lookup pending while the table is still being filled");
`endif

endmodule

### design/sts_queue.sv
// Short FIFO between the front end and the back end of the tone generator.
// Depends on sts_pkg for the entry type.
module sts_queue #(
  parameter int DEPTH = sts_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sts_pkg::qentry_t push_data,
  output logic             full,
  input  logic             pop,
  output sts_pkg::qentry_t pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sts_pkg::qentry_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue pop while empty");
`endif

endmodule

### design/sts_back.sv
// Back end: amplitude scaling, PCM rounding or float packing, per-channel emission.
// Depends on sts_pkg; takes entries from the queue and drives the sample channel.
module sts_back #(
  parameter int MAX_CHANNELS = sts_pkg::DEFAULT_MAX_CHANNELS
) (
  input  logic             clk,
  input  logic             rst,
  input  sts_pkg::cfg_t    cfg,
  input  sts_pkg::qentry_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             sample_valid,
  input  logic             sample_stall,
  output sts_pkg::sample_t sample_data
);

  localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW      = sts_pkg::SINE_WIDTH;
  localparam int AW      = sts_pkg::AMP_WIDTH;
  localparam int MW      = SW + AW;

  sts_pkg::back_state_t state;
  sts_pkg::back_state_t state_next;

  logic [SW-1:0]      sine;
  logic               neg;
  logic               blast;
  logic [CH_BITS-1:0] last_ch;
  logic [CH_BITS-1:0] last_calc;
  logic [CH_BITS-1:0] chan;
  logic [MW-1:0]      mag;
  logic [MW-1:0]      product;
  logic [62:0]        scaled;
  logic [62:0]        scaled_calc;
  logic [63:0]        mag64;
  logic [63:0]        shifted;
  logic [MW-1:0]      norm;
  logic [4:0]         norm_p;
  logic [31:0]        word;
  logic [31:0]        word_calc;
  logic [31:0]        pcm_mag;
  logic [31:0]        pcm_signed;
  logic               round_up;
  logic [24:0]        mant_sum;
  logic [22:0]        mant;
  logic [7:0]         expo;
  logic [4:0]         cnt5;

  // Clamp the configured channel count to 1..MAX_CHANNELS, as a last index
  assign cnt5 = {1'b0, cfg.channel_count};
  always_comb begin
    if (cnt5 == 5'd0) begin
      last_calc = '0;
    end else if (cnt5 > 5'(MAX_CHANNELS)) begin
      last_calc = CH_BITS'(MAX_CHANNELS - 1);
    end else begin
      last_calc = CH_BITS'(cnt5 - 5'd1);
    end
  end

  // Scale the table magnitude by the amplitude
  assign product = MW'(sine) * MW'(cfg.amplitude);

  // PCM: magnitude times full scale plus one half, by shift and subtract
  assign mag64 = {{(64 - MW){1'b0}}, mag};
  always_comb begin
    case (cfg.out_format)
      sts_pkg::FMT_PCM16: shifted = mag64 << sts_pkg::PCM16_SHIFT;
      sts_pkg::FMT_PCM24: shifted = mag64 << sts_pkg::PCM24_SHIFT;
      default:            shifted = mag64 << sts_pkg::PCM32_SHIFT;
    endcase
  end
  assign scaled_calc = 63'(shifted - mag64 + sts_pkg::PCM_ROUND);

  assign pcm_mag    = {1'b0, scaled[62:32]};
  assign pcm_signed = neg ? (32'd0 - pcm_mag) : pcm_mag;

  // Float: round the normalized magnitude to 24 bits, nearest even
  assign round_up = norm[6] && ((norm[5:0] != '0) || norm[7]);
  assign mant_sum = {1'b0, norm[30:7]} + {24'd0, round_up};
  assign mant     = mant_sum[24] ? mant_sum[23:1] : mant_sum[22:0];
  assign expo     = {3'd0, norm_p} + sts_pkg::FLOAT_EXP_BASE + {7'd0, mant_sum[24]};

  // Select the output word by format
  always_comb begin
    case (cfg.out_format)
      sts_pkg::FMT_FLOAT32: word_calc = (mag == '0) ? 32'd0 : {neg, expo, mant};
      sts_pkg::FMT_PCM16:   word_calc = pcm_signed & sts_pkg::PCM16_MASK;
      sts_pkg::FMT_PCM24:   word_calc = pcm_signed & sts_pkg::PCM24_MASK;
      default:              word_calc = pcm_signed;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      sts_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = sts_pkg::BK_MUL;
        end
      end
      sts_pkg::BK_MUL: begin
        state_next = (cfg.out_format == sts_pkg::FMT_FLOAT32) ?
                     sts_pkg::BK_NORM : sts_pkg::BK_SCALE;
      end
      sts_pkg::BK_SCALE: state_next = sts_pkg::BK_PACK;
      sts_pkg::BK_NORM: begin
        if ((norm == '0) || norm[MW-1]) begin
          state_next = sts_pkg::BK_PACK;
        end
      end
      sts_pkg::BK_PACK: state_next = sts_pkg::BK_EMIT;
      sts_pkg::BK_EMIT: begin
        if (!sample_stall && (chan == last_ch)) begin
          state_next = sts_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // Datapath registers, one step per state
  always_ff @(posedge clk) begin
    unique case (state)
      sts_pkg::BK_IDLE: begin
        if (!q_empty) begin
          sine    <= q_data.sine;
          neg     <= q_data.neg;
          blast   <= q_data.block_last;
          last_ch <= last_calc;
          chan    <= '0;
        end
      end
      sts_pkg::BK_MUL: begin
        mag    <= product;
        norm   <= product;
        norm_p <= sts_pkg::NORM_TOP_POS;
      end
      sts_pkg::BK_SCALE: scaled <= scaled_calc;
      sts_pkg::BK_NORM: begin
        // Shift the leading one up to the top bit, eight places or one at a time
        if ((norm != '0) && !norm[MW-1]) begin
          if (norm[MW-1 -: 8] == '0) begin
            norm   <= norm << 8;
            norm_p <= norm_p - 5'd8;
          end else begin
            norm   <= norm << 1;
            norm_p <= norm_p - 5'd1;
          end
        end
      end
      sts_pkg::BK_PACK: word <= word_calc;
      sts_pkg::BK_EMIT: begin
        if (!sample_stall && (chan != last_ch)) begin
          chan <= chan + 1'b1;
        end
      end
    endcase
  end

  // Output register drives the sample channel
  assign sample_valid                 = (state == sts_pkg::BK_EMIT);
  assign sample_data.sample_word      = word;
  assign sample_data.channel_index    = 3'({3'b000, chan});
  assign sample_data.last_channel     = (chan == last_ch);
  assign sample_data.frame_block_last = blast;

`ifndef NO_ASSERTIONS
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && sample_data.last_channel)
      |=> (state == sts_pkg::BK_IDLE))
    else $error("back end did not finish the frame after its last channel");
  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sts_pkg::BK_EMIT) |-> (chan <= last_ch))
    else $error("channel counter ran past the configured channel count");
`endif

endmodule
